[rtl/ecvs_pkg.sv]
package ecvs_pkg;

  // frame store geometry
  localparam int unsigned FRAME_COUNT = 1024;
  localparam int unsigned FRAME_AW    = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;

  typedef logic [FRAME_AW-1:0] frame_addr_t;
  typedef logic [3:0]          marks_t;

  localparam frame_addr_t LAST_FRAME = frame_addr_t'(FRAME_COUNT - 1);

  // mark bit positions
  localparam int unsigned MARK_RES   = 0;
  localparam int unsigned MARK_ACC   = 1;
  localparam int unsigned MARK_DIRTY = 2;
  localparam int unsigned MARK_WB    = 3;

  localparam marks_t MARKS_CLEAR     = 4'b0000;
  localparam marks_t MARKS_INSTALLED = 4'b0001;

  localparam logic [3:0] SWEEP_LIMIT_RESET = 4'd2;

  typedef enum logic [1:0] {
    CMD_ACCESS  = 2'd0,
    CMD_INSTALL = 2'd1,
    CMD_FREE    = 2'd2,
    CMD_VICTIM  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_SWEEP
  } state_e;

  // write port of the mark store
  typedef struct packed {
    logic        en;
    frame_addr_t addr;
    marks_t      data;
  } mark_wr_t;

  // read port of the mark store
  typedef struct packed {
    logic        en;
    frame_addr_t addr;
  } mark_rd_t;

  typedef struct packed {
    logic   victim;
    marks_t marks;
  } sweep_res_t;

  // one step of the enhanced second-chance sweep on a frame's marks
  function automatic sweep_res_t sweep_step(marks_t m);
    sweep_res_t r;
    r.victim = 1'b0;
    r.marks  = m;
    if (m[MARK_RES]) begin
      if (!m[MARK_ACC] && !m[MARK_DIRTY]) begin
        r.victim = 1'b1;
        r.marks  = MARKS_CLEAR;
      end else if (m[MARK_ACC] && !m[MARK_DIRTY]) begin
        r.marks[MARK_ACC] = 1'b0;
      end else if (m[MARK_ACC] && m[MARK_DIRTY]) begin
        r.marks[MARK_DIRTY] = 1'b0;
        r.marks[MARK_WB]    = 1'b1;
      end
    end
    return r;
  endfunction

  // circular successor of a frame
  function automatic frame_addr_t next_frame(frame_addr_t p);
    frame_addr_t n;
    if (p == LAST_FRAME) begin
      n = '0;
    end else begin
      n = p + frame_addr_t'(1);
    end
    return n;
  endfunction

endpackage

[rtl/ecvs_mark_ram.sv]
module ecvs_mark_ram
  import ecvs_pkg::*;
(
  input  logic     clk_i,
  input  mark_wr_t wr_i,
  input  mark_rd_t rd_i,
  output marks_t   rdata_o
);

  marks_t mem_q [FRAME_COUNT];
  marks_t rdata_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/enhanced_clock_victim_select_unit.sv]
// Enhanced second-chance clock victim selector.
// Input channel (in_valid_i/in_ready_o) carries a command, a frame index and a
// write flag. Access, install and free update the per-frame marks and give no
// result; a victim request gives one result transaction on the output channel
// (out_valid_o/out_ready_i) with the victim frame, found flag and write-back mark.
// Install and free write the store directly; access is a read then a write of the store.
// A victim request starts at the frame after the last victim: the sweep
// reads one frame of the mark store per cycle, at most sweep_limit*FRAME_COUNT+1 frames.
// The result appears in the cycle after the sweep ends.
// The sweep limit register is written with cfg_we_i/cfg_data_i; reset value 2.
// After reset the mark store is cleared, one frame per cycle, while in_ready_o
// is low. The last victim resets to the last frame.
// The result sits in an output register; while it waits, access, install and
// free transactions are still taken, a further victim request is held off until
// the pending result has been taken.
module enhanced_clock_victim_select_unit
  import ecvs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] in_command_i,
  input  logic [9:0] in_frame_index_i,
  input  logic       in_is_write_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [9:0] out_victim_frame_o,
  output logic       out_found_o,
  output logic       out_needs_writeback_o
);

  state_e      state_q, state_d;
  frame_addr_t clr_q, clr_d;
  frame_addr_t last_victim_q, last_victim_d;
  logic [3:0]  sweep_limit_q;
  logic        out_valid_q, out_valid_d;

  frame_addr_t pos_q, pos_d;
  frame_addr_t cnt_q, cnt_d;
  logic [3:0]  rem_q, rem_d;
  frame_addr_t acc_addr_q, acc_addr_d;
  logic        acc_wr_q, acc_wr_d;

  logic        res_load;
  logic [9:0]  res_frame;
  logic        res_found;
  logic        res_wb;
  logic [9:0]  victim_frame_q;
  logic        found_q;
  logic        wb_q;

  mark_wr_t    mark_wr;
  mark_rd_t    mark_rd;
  marks_t      mark_rdata;
  sweep_res_t  step;
  frame_addr_t start_pos;
  frame_addr_t in_addr;
  logic        idx_ok;
  logic        in_fire;
  cmd_e        cmd;

  ecvs_mark_ram u_mark_ram (
    .clk_i   (clk_i),
    .wr_i    (mark_wr),
    .rd_i    (mark_rd),
    .rdata_o (mark_rdata)
  );

  assign cmd       = cmd_e'(in_command_i);
  assign in_addr   = frame_addr_t'(in_frame_index_i);
  assign idx_ok    = 32'(in_frame_index_i) < FRAME_COUNT;
  assign start_pos = next_frame(last_victim_q);
  assign step      = sweep_step(mark_rdata);

  // a victim request waits for a free result slot
  assign in_ready_o = (state_q == ST_IDLE) &&
                      (!out_valid_q || out_ready_i || (cmd != CMD_VICTIM));
  assign in_fire    = in_valid_i && in_ready_o;

  // sequencer: store clear, command handling and the sweep
  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    last_victim_d = last_victim_q;
    pos_d         = pos_q;
    cnt_d         = cnt_q;
    rem_d         = rem_q;
    acc_addr_d    = acc_addr_q;
    acc_wr_d      = acc_wr_q;
    mark_wr       = '{en: 1'b0, addr: pos_q, data: MARKS_CLEAR};
    mark_rd       = '{en: 1'b0, addr: pos_q};
    res_load      = 1'b0;
    res_frame     = '0;
    res_found     = 1'b0;
    res_wb        = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        mark_wr = '{en: 1'b1, addr: clr_q, data: MARKS_CLEAR};
        clr_d   = clr_q + frame_addr_t'(1);
        if (clr_q == LAST_FRAME) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd)
            CMD_ACCESS: begin
              if (idx_ok) begin
                mark_rd    = '{en: 1'b1, addr: in_addr};
                acc_addr_d = in_addr;
                acc_wr_d   = in_is_write_i;
                state_d    = ST_ACCESS;
              end
            end
            CMD_INSTALL: begin
              if (idx_ok) begin
                mark_wr = '{en: 1'b1, addr: in_addr, data: MARKS_INSTALLED};
              end
            end
            CMD_FREE: begin
              if (idx_ok) begin
                mark_wr = '{en: 1'b1, addr: in_addr, data: MARKS_CLEAR};
              end
            end
            CMD_VICTIM: begin
              mark_rd = '{en: 1'b1, addr: start_pos};
              pos_d   = start_pos;
              cnt_d   = '0;
              rem_d   = sweep_limit_q;
              state_d = ST_SWEEP;
            end
            default: ;
          endcase
        end
      end

      // second half of the access read-modify-write
      ST_ACCESS: begin
        if (mark_rdata[MARK_RES]) begin
          mark_wr.en   = 1'b1;
          mark_wr.addr = acc_addr_q;
          mark_wr.data = mark_rdata;
          mark_wr.data[MARK_ACC] = 1'b1;
          if (acc_wr_q) begin
            mark_wr.data[MARK_DIRTY] = 1'b1;
          end
        end
        state_d = ST_IDLE;
      end

      // one frame per cycle: update marks, fetch the next frame
      ST_SWEEP: begin
        mark_wr = '{en: 1'b1, addr: pos_q, data: step.marks};
        if (step.victim) begin
          res_load      = 1'b1;
          res_frame     = 10'(pos_q);
          res_found     = 1'b1;
          res_wb        = mark_rdata[MARK_WB];
          last_victim_d = pos_q;
          state_d       = ST_IDLE;
        end else if (rem_q == 4'd0) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          pos_d   = next_frame(pos_q);
          mark_rd = '{en: 1'b1, addr: next_frame(pos_q)};
          if (cnt_q == LAST_FRAME) begin
            cnt_d = '0;
            rem_d = rem_q - 4'd1;
          end else begin
            cnt_d = cnt_q + frame_addr_t'(1);
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // output slot
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (res_load) begin
      out_valid_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      last_victim_q <= LAST_FRAME;
      sweep_limit_q <= SWEEP_LIMIT_RESET;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      clr_q         <= clr_d;
      last_victim_q <= last_victim_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        sweep_limit_q <= cfg_data_i;
      end
    end
  end

  // sweep and access working registers
  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    cnt_q      <= cnt_d;
    rem_q      <= rem_d;
    acc_addr_q <= acc_addr_d;
    acc_wr_q   <= acc_wr_d;
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      victim_frame_q <= res_frame;
      found_q        <= res_found;
      wb_q           <= res_wb;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_victim_frame_o    = victim_frame_q;
  assign out_found_o           = found_q;
  assign out_needs_writeback_o = wb_q;

endmodule
